@@ rtl/bcd_digit_frame_serializer_macros.svh @@
// ----------------------------------------------------------------------------
// bcd digit frame serializer assertion macros
// shared concurrent assertion forms, clocked on clk and disabled in rst
// ----------------------------------------------------------------------------
`ifndef BCD_DIGIT_FRAME_SERIALIZER_MACROS_SVH
`define BCD_DIGIT_FRAME_SERIALIZER_MACROS_SVH

// same-cycle implication
`define BCDFS_ASSERT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define BCDFS_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ rtl/bcdfs_pkg.sv @@
// ----------------------------------------------------------------------------
// bcdfs_pkg
// request codes, frame positions and the result type of the digit serializer
// ----------------------------------------------------------------------------
package bcdfs_pkg;

  localparam logic [1:0] REQ_TICK   = 2'd0;
  localparam logic [1:0] REQ_APPEND = 2'd1;
  localparam logic [1:0] REQ_COMMIT = 2'd2;

  localparam logic [2:0] POS_START = 3'd0;
  localparam logic [2:0] POS_DATA_END = 3'd4;
  localparam logic [2:0] POS_STOP  = 3'd5;

  localparam logic [9:0] PERIOD_RESET = 10'd3;
  localparam logic [9:0] ELAPSED_SAT  = 10'h3FF;

  localparam logic [7:0] ASCII_ZERO = 8'h30;
  localparam logic [7:0] DIGIT_MAX  = 8'd9;

  typedef struct packed {
    logic       bit_valid;
    logic       bit_value;
    logic [2:0] frame_position;
    logic       message_done;
    logic       busy_res;
  } res_t;

  // non-digit characters map to zero
  function automatic logic [3:0] to_bcd(input logic [7:0] code);
    logic [7:0] d;
    d = code - ASCII_ZERO;
    return (d > DIGIT_MAX) ? 4'd0 : d[3:0];
  endfunction

endpackage

@@ rtl/bcdfs_if.sv @@
// ----------------------------------------------------------------------------
// bcdfs channel interfaces
// request, result and configuration channels with valid / ready handshake
// ----------------------------------------------------------------------------
interface bcdfs_req_if;
  logic       valid;
  logic       ready;
  logic [1:0] req_type;
  logic [7:0] char_code;
  modport source (output valid, output req_type, output char_code, input ready);
  modport sink   (input valid, input req_type, input char_code, output ready);
endinterface

interface bcdfs_res_if;
  logic       valid;
  logic       ready;
  logic       bit_valid;
  logic       bit_value;
  logic [2:0] frame_position;
  logic       message_done;
  logic       busy_res;
  modport source (output valid, output bit_valid, output bit_value,
                  output frame_position, output message_done, output busy_res,
                  input ready);
  modport sink   (input valid, input bit_valid, input bit_value,
                  input frame_position, input message_done, input busy_res,
                  output ready);
endinterface

interface bcdfs_cfg_if;
  logic       valid;
  logic       ready;
  logic [9:0] data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

@@ rtl/bcdfs_ctrl.sv @@
// ----------------------------------------------------------------------------
// bcdfs_ctrl
// digit store memory, message counters and bit timing; while in_ready holds, one item per cycle
// ----------------------------------------------------------------------------
`include "bcd_digit_frame_serializer_macros.svh"

module bcdfs_ctrl import bcdfs_pkg::*; #(
  parameter int MSG_DEPTH = 32
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  input  logic       in_ready,
  input  logic [1:0] req_type,
  input  logic [7:0] char_code,
  input  logic       cfg_valid,
  input  logic [9:0] cfg_data,
  output logic       res_valid,
  output res_t       res
);

  localparam int CW = $clog2(MSG_DEPTH);
  localparam logic [CW-1:0] FULL_MARK = CW'(MSG_DEPTH - 1);

  logic [3:0] store [MSG_DEPTH];
  logic [3:0] digit;  // registered read port, loaded at frame start

  logic [9:0]    period;
  logic [CW-1:0] pending, pending_next;
  logic [CW-1:0] length, length_next;
  logic [CW-1:0] charpos, charpos_next;
  logic          active, active_next;
  logic [2:0]    bitpos, bitpos_next;
  logic [9:0]    elapsed, elapsed_next;

  logic       acc;
  logic       wr_en;
  logic       rd_en;
  logic       go;
  logic [2:0] pos_eff;
  logic [9:0] el;
  res_t       res_c;

  assign acc = in_valid && in_ready;

  always_comb begin
    pending_next = pending;
    length_next  = length;
    charpos_next = charpos;
    active_next  = active;
    bitpos_next  = bitpos;
    elapsed_next = elapsed;
    wr_en   = 1'b0;
    rd_en   = 1'b0;
    go      = 1'b0;
    pos_eff = bitpos;
    el      = elapsed;
    res_c   = '0;
    unique case (req_type)
      REQ_APPEND: begin
        if (pending < FULL_MARK) begin
          wr_en        = 1'b1;
          pending_next = pending + 1'b1;
        end
      end
      REQ_COMMIT: begin
        if (pending != '0) length_next = pending;
        pending_next = '0;
      end
      REQ_TICK: begin
        if (length != '0) begin
          go = 1'b1;
          if (!active) begin
            if (charpos >= length) begin
              length_next  = '0;
              charpos_next = '0;
              res_c.message_done = 1'b1;
              go = 1'b0;
            end else begin
              rd_en        = 1'b1;
              pos_eff      = POS_START;
              charpos_next = charpos + 1'b1;
              active_next  = 1'b1;
              el           = '0;
            end
          end else if (elapsed != ELAPSED_SAT) begin
            el = elapsed + 10'd1;
          end
          elapsed_next = el;
          bitpos_next  = pos_eff;
          if (go && el >= period) begin
            elapsed_next         = '0;
            res_c.bit_valid      = 1'b1;
            res_c.frame_position = pos_eff;
            priority if (pos_eff == POS_START) res_c.bit_value = 1'b1;
            else if (pos_eff <= POS_DATA_END) res_c.bit_value = digit[2'(POS_DATA_END - pos_eff)];
            else res_c.bit_value = 1'b0;
            if (pos_eff == POS_STOP) begin
              bitpos_next = POS_START;
              active_next = 1'b0;
            end else begin
              bitpos_next = pos_eff + 3'd1;
            end
          end
        end
      end
      default: ;
    endcase
    res_c.busy_res = (length_next != '0);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      period  <= PERIOD_RESET;
      pending <= '0;
      length  <= '0;
      charpos <= '0;
      active  <= 1'b0;
      bitpos  <= POS_START;
      elapsed <= '0;
    end else begin
      if (cfg_valid) period <= cfg_data;
      if (acc) begin
        pending <= pending_next;
        length  <= length_next;
        charpos <= charpos_next;
        active  <= active_next;
        bitpos  <= bitpos_next;
        elapsed <= elapsed_next;
      end
    end
  end

  // store: one write port at pending, one registered read port at charpos
  always_ff @(posedge clk) begin
    if (acc && wr_en) store[pending] <= to_bcd(char_code);
    if (acc && rd_en) digit <= store[charpos];
  end

  assign res_valid = acc;
  assign res       = res_c;

  `BCDFS_ASSERT(a_active_has_len, active, length != '0, "frame active with no message")
  `BCDFS_ASSERT(a_pending_bound, 1'b1, pending <= FULL_MARK, "pending count past store")
  `BCDFS_ASSERT_NEXT(a_emit_restart, acc && res_c.bit_valid, elapsed == '0,
                     "bit timer not restarted after emit")

endmodule

@@ rtl/bcdfs_skid.sv @@
// ----------------------------------------------------------------------------
// bcdfs_skid
// two-entry output buffer; ready toward the controller is registered
// ----------------------------------------------------------------------------
`include "bcd_digit_frame_serializer_macros.svh"

module bcdfs_skid import bcdfs_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  output logic in_ready,
  input  res_t in_data,
  output logic out_valid,
  input  logic out_ready,
  output res_t out_data
);

  logic main_v, skid_v;
  res_t main_q, skid_q;
  logic push, pop;

  assign in_ready  = !skid_v;
  assign push      = in_valid && in_ready;
  assign pop       = main_v && out_ready;
  assign out_valid = main_v;
  assign out_data  = main_q;

  always_ff @(posedge clk) begin
    if (rst) begin
      main_v <= 1'b0;
      skid_v <= 1'b0;
    end else if (!main_v || pop) begin
      if (skid_v) begin
        main_v <= 1'b1;
        skid_v <= push;
      end else begin
        main_v <= push;
      end
    end else if (push) begin
      skid_v <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!main_v || pop) begin
      if (skid_v) begin
        main_q <= skid_q;
        if (push) skid_q <= in_data;
      end else if (push) begin
        main_q <= in_data;
      end
    end else if (push) begin
      skid_q <= in_data;
    end
  end

  `BCDFS_ASSERT(a_skid_behind_main, skid_v, main_v, "skid entry without main entry")
  `BCDFS_ASSERT_NEXT(a_overflow_kept, main_v && !pop && push, skid_v, "item lost on stall")
  `BCDFS_ASSERT_NEXT(a_skid_kept, skid_v && !pop, skid_v && main_v, "buffered item dropped")

endmodule

@@ rtl/bcd_digit_frame_serializer.sv @@
// ----------------------------------------------------------------------------
// bcd_digit_frame_serializer
// stores decimal digits and sends them as six-bit frames, one bit per period
// ----------------------------------------------------------------------------
//  channel  role  payload                                     accepted when
//  req      sink  req_type, char_code                         valid && ready
//  res      src   bit_valid, bit_value, frame_position,       valid && ready
//                 message_done, busy_res
//  cfg      sink  data (ticks per line bit)                   valid && ready
//
//  one item per cycle while req.ready is high; each item gives one result item, registered in the output buffer
//  the digit store is a single synchronous memory, read once per frame start
//  req.ready drops only while both output buffer entries are full
//  rst clears counters, timer and period (to 3); store contents stay unknown
//  cfg.ready is always high
// ----------------------------------------------------------------------------
module bcd_digit_frame_serializer import bcdfs_pkg::*; #(
  parameter int MSG_DEPTH = 32
) (
  input  logic        clk,
  input  logic        rst,
  bcdfs_req_if.sink   req,
  bcdfs_res_if.source res,
  bcdfs_cfg_if.sink   cfg
);

  logic ctrl_ready;   // buffer has room for the result of this item
  logic ctrl_valid;
  res_t ctrl_res;
  res_t out_res;

  assign req.ready = ctrl_ready;
  assign cfg.ready = 1'b1;

  // controller: store, counters and bit timer, result computed on accept
  bcdfs_ctrl #(
    .MSG_DEPTH (MSG_DEPTH)
  ) u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (req.valid),
    .in_ready  (ctrl_ready),
    .req_type  (req.req_type),
    .char_code (req.char_code),
    .cfg_valid (cfg.valid),
    .cfg_data  (cfg.data),
    .res_valid (ctrl_valid),
    .res       (ctrl_res)
  );

  // output buffer decouples result stalls from the request side
  bcdfs_skid u_skid (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (ctrl_valid),
    .in_ready  (ctrl_ready),
    .in_data   (ctrl_res),
    .out_valid (res.valid),
    .out_ready (res.ready),
    .out_data  (out_res)
  );

  assign res.bit_valid      = out_res.bit_valid;
  assign res.bit_value      = out_res.bit_value;
  assign res.frame_position = out_res.frame_position;
  assign res.message_done   = out_res.message_done;
  assign res.busy_res       = out_res.busy_res;

endmodule

@@ sim/bcdfs_line_monitor.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bcdfs line monitor
// watches the request, result and configuration channels of the digit
// serializer, predicts every result item and compares it field by field
// ----------------------------------------------------------------------------
module bcdfs_line_monitor import bcdfs_pkg::*; #(
  parameter int MSG_DEPTH = 32
) (
  input  logic  clk,
  input  logic  rst,
  bcdfs_req_if  req,
  bcdfs_res_if  res,
  bcdfs_cfg_if  cfg,
  output int    mismatches,
  output int    results_due,
  output int    results_seen,
  output int    bits_seen,
  output int    messages_seen
);

  // predicted serializer state
  logic [3:0] digit_mem [MSG_DEPTH];
  logic [5:0] pend_cnt;
  logic [5:0] msg_len;
  logic [5:0] send_pos;
  logic       in_frame;
  logic [2:0] bit_idx;
  logic [3:0] cur_digit;
  logic [9:0] tick_cnt;
  logic [9:0] period;

  res_t line_queue [$];
  int   errs = 0;
  int   n_results = 0;
  int   n_bits = 0;
  int   n_done = 0;

  task automatic advance_serializer(input logic [1:0] kind, input logic [7:0] code);
    res_t       r;
    logic [7:0] d;
    logic       go;
    r  = '0;
    go = 1'b1;
    case (kind)
      REQ_APPEND: begin
        if (pend_cnt < MSG_DEPTH - 1) begin
          d = code - ASCII_ZERO;
          digit_mem[pend_cnt] = (d > DIGIT_MAX) ? 4'd0 : d[3:0];
          pend_cnt++;
        end
      end
      REQ_COMMIT: begin
        if (pend_cnt != 0) msg_len = pend_cnt;
        pend_cnt = '0;
      end
      REQ_TICK: begin
        if (msg_len != 0) begin
          if (!in_frame) begin
            if (send_pos >= msg_len) begin
              msg_len = '0;
              send_pos = '0;
              r.message_done = 1'b1;
              go = 1'b0;
            end else begin
              cur_digit = digit_mem[send_pos];
              bit_idx = POS_START;
              send_pos++;
              in_frame = 1'b1;
              tick_cnt = '0;
            end
          end else if (tick_cnt < ELAPSED_SAT) begin
            tick_cnt++;
          end
          if (go && tick_cnt >= period) begin
            tick_cnt = '0;
            r.bit_valid = 1'b1;
            r.frame_position = bit_idx;
            if (bit_idx == POS_START) r.bit_value = 1'b1;
            else if (bit_idx <= POS_DATA_END) r.bit_value = cur_digit[2'(POS_DATA_END - bit_idx)];
            else r.bit_value = 1'b0;
            if (bit_idx == POS_STOP) begin
              bit_idx = POS_START;
              in_frame = 1'b0;
            end else begin
              bit_idx++;
            end
          end
        end
      end
      default: ;
    endcase
    r.busy_res = (msg_len != 0);
    line_queue.push_back(r);
  endtask

  task automatic compare_field(input string name, input logic [2:0] want, input logic [2:0] got);
    if (want !== got) begin
      errs++;
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
    end
  endtask

  task automatic check_result();
    res_t want;
    if (line_queue.size() == 0) begin
      errs++;
      $display("%0t: result item with no item pending, expected none, actual %b",
               $time, {res.bit_valid, res.bit_value, res.frame_position,
                       res.message_done, res.busy_res});
    end else begin
      want = line_queue.pop_front();
      compare_field("bit_valid", 3'(want.bit_valid), 3'(res.bit_valid));
      compare_field("bit_value", 3'(want.bit_value), 3'(res.bit_value));
      compare_field("frame_position", want.frame_position, res.frame_position);
      compare_field("message_done", 3'(want.message_done), 3'(res.message_done));
      compare_field("busy_res", 3'(want.busy_res), 3'(res.busy_res));
    end
    n_results++;
    if (res.bit_valid === 1'b1) n_bits++;
    if (res.message_done === 1'b1) n_done++;
  endtask

  always @(posedge clk) begin
    if (rst) begin
      pend_cnt = '0;
      msg_len  = '0;
      send_pos = '0;
      in_frame = 1'b0;
      bit_idx  = '0;
      cur_digit = '0;
      tick_cnt = '0;
      period   = PERIOD_RESET;
      line_queue.delete();
    end else begin
      if (res.valid && res.ready) check_result();
      if (req.valid && req.ready) advance_serializer(req.req_type, req.char_code);
      if (cfg.valid && cfg.ready) period = cfg.data;
    end
    mismatches    <= errs;
    results_due   <= line_queue.size();
    results_seen  <= n_results;
    bits_seen     <= n_bits;
    messages_seen <= n_done;
  end

endmodule

@@ sim/bcd_digit_frame_serializer_tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bcd_digit_frame_serializer testbench
// drives digit appends, commits and ticks through the request
// channel under several bit periods, with random gaps and receiver stalls;
// the line monitor predicts and checks every result item
// ----------------------------------------------------------------------------
module bcd_digit_frame_serializer_tb;
  import bcdfs_pkg::*;

  localparam int MSG_DEPTH    = 32;
  localparam int CYCLE_LIMIT  = 400000;
  localparam int HOLD_CYCLES  = 80;
  localparam int RANDOM_ITEMS = 300;
  localparam int PHASES       = 5;
  // request code the block must ignore
  localparam logic [1:0] REQ_UNUSED = 2'd3;
  localparam logic [9:0] PERIOD_MAX = 10'h3FF;

  logic clk;
  logic rst;

  bcdfs_req_if req_ch ();
  bcdfs_res_if res_ch ();
  bcdfs_cfg_if cfg_ch ();

  // monitor outputs
  int mismatches;
  int results_due;
  int results_seen;
  int bits_seen;
  int messages_seen;

  // stimulus bookkeeping
  int   items_sent = 0;
  int   period_writes = 0;
  int   cycle_count = 0;
  logic gaps_on = 1'b1;
  logic stall_on = 1'b1;
  // each bump of hold_seq asks the receiver for one long hold-off
  int   hold_seq = 0;
  int   hold_seen = 0;

  bcd_digit_frame_serializer #(.MSG_DEPTH(MSG_DEPTH)) i_dut (
    .clk (clk),
    .rst (rst),
    .req (req_ch),
    .res (res_ch),
    .cfg (cfg_ch)
  );

  bcdfs_line_monitor #(.MSG_DEPTH(MSG_DEPTH)) u_monitor (
    .clk           (clk),
    .rst           (rst),
    .req           (req_ch),
    .res           (res_ch),
    .cfg           (cfg_ch),
    .mismatches    (mismatches),
    .results_due   (results_due),
    .results_seen  (results_seen),
    .bits_seen     (bits_seen),
    .messages_seen (messages_seen)
  );

  // 4 ns clock
  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // run limit, far above the slowest correct run
  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("Verification failed");
    $finish;
  end

  // result receiver: random stalls, or none, plus long hold-offs on request
  initial begin
    res_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_seq != hold_seen) begin
        hold_seen = hold_seq;
        // hold ready low so the output buffer fills and req.ready drops
        for (int n = 0; n < HOLD_CYCLES; n++) begin
          res_ch.ready <= 1'b0;
          @(posedge clk);
        end
      end
      res_ch.ready <= stall_on ? ($urandom_range(99) >= 33) : 1'b1;
    end
  end

  // offer one item and wait until it is taken; valid stays high afterwards
  // so a back-to-back item needs only one assignment in that step
  task automatic send_item(input logic [1:0] kind, input logic [7:0] code);
    if (gaps_on) begin
      while ($urandom_range(99) < 33) begin
        req_ch.valid <= 1'b0;
        @(posedge clk);
      end
    end
    req_ch.valid     <= 1'b1;
    req_ch.req_type  <= kind;
    req_ch.char_code <= code;
    @(posedge clk);
    while (!req_ch.ready) @(posedge clk);
    if (kind != REQ_UNUSED) items_sent++;
  endtask

  // ticks with the odd ignored request mixed in
  task automatic send_ticks(input int count);
    for (int n = 0; n < count; n++) begin
      if ($urandom_range(29) == 0) send_item(REQ_UNUSED, 8'($urandom));
      send_item(REQ_TICK, 8'($urandom));
    end
  endtask

  // drop valid and wait until every predicted result item has come back;
  // the first edge lets the monitor count the last accepted item
  task automatic wait_idle();
    req_ch.valid <= 1'b0;
    @(posedge clk);
    while (results_due != 0) @(posedge clk);
  endtask

  // period writes only happen with nothing in flight
  task automatic write_period(input logic [9:0] p);
    wait_idle();
    cfg_ch.valid <= 1'b1;
    cfg_ch.data  <= p;
    @(posedge clk);
    while (!cfg_ch.ready) @(posedge clk);
    cfg_ch.valid <= 1'b0;
    period_writes++;
  endtask

  // mostly ascii digits, sometimes any byte (non-digits map to zero)
  function automatic logic [7:0] pick_char();
    if ($urandom_range(3) == 0) return 8'($urandom_range(255));
    return ASCII_ZERO + 8'($urandom_range(9));
  endfunction

  // one message: appends, commit, then enough ticks to send it all
  task automatic run_message(input int digits, input int p);
    int ticks;
    int cut;
    int extra;
    // empty commit, pending is usually zero here
    if ($urandom_range(15) == 0) send_item(REQ_COMMIT, 8'($urandom));
    for (int n = 0; n < digits; n++) begin
      if ($urandom_range(9) == 0) send_item(REQ_UNUSED, 8'($urandom));
      send_item(REQ_APPEND, pick_char());
    end
    send_item(REQ_COMMIT, 8'($urandom));
    // a frame takes 6 * p + 1 ticks, or 6 ticks with a zero period
    ticks = ((digits > MSG_DEPTH - 1) ? MSG_DEPTH - 1 : digits)
            * ((p == 0) ? 6 : 6 * p + 1) + 1 + $urandom_range(3);
    if ($urandom_range(4) == 0) begin
      // commit in the middle of a message, overwriting shared store entries
      cut = $urandom_range(ticks, 1);
      send_ticks(cut);
      extra = $urandom_range(3, 1);
      for (int n = 0; n < extra; n++) send_item(REQ_APPEND, pick_char());
      send_item(REQ_COMMIT, 8'($urandom));
    end
    send_ticks(ticks);
  endtask

  initial begin
    int         phase_period [PHASES];
    int         phase_target;
    logic [9:0] rand_period;

    rst              <= 1'b1;
    req_ch.valid     <= 1'b0;
    req_ch.req_type  <= REQ_TICK;
    req_ch.char_code <= 8'h00;
    cfg_ch.valid     <= 1'b0;
    cfg_ch.data      <= '0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // directed part, starting on the reset period
    send_item(REQ_APPEND, ASCII_ZERO + 8'd9);
    // non-digit characters become zero
    send_item(REQ_APPEND, 8'hFF);
    send_item(REQ_COMMIT, 8'h00);
    // empty commit keeps the length
    send_item(REQ_COMMIT, 8'hFF);
    send_item(REQ_UNUSED, 8'hA5);
    // frame-start tick plus three ticks to the start bit
    send_ticks(4);
    // zero period in the middle of a frame: a bit on every tick
    write_period('0);
    send_ticks(5);
    // commit during the message rewrites the digit not yet sent
    send_item(REQ_APPEND, ASCII_ZERO);
    send_item(REQ_APPEND, ASCII_ZERO + 8'd1);
    send_item(REQ_COMMIT, 8'h00);
    send_ticks(7);

    // store full: appends beyond depth minus one are dropped
    run_message(MSG_DEPTH + 2, 0);

    // back pressure: receiver holds off while the sender keeps offering
    run_message(5, 0);
    wait_idle();
    hold_seq <= hold_seq + 1;
    gaps_on = 1'b0;
    send_ticks(40);
    gaps_on = 1'b1;

    // longest period: the start bit only after the counter reaches the top
    write_period(PERIOD_MAX);
    send_item(REQ_APPEND, ASCII_ZERO + 8'd7);
    send_item(REQ_COMMIT, 8'h00);
    send_ticks(1030);

    // random phases; the first one starts while that frame is still open
    phase_period[0] = 1;
    phase_period[1] = 3;
    phase_period[2] = 2;
    phase_period[3] = $urandom_range(6);
    phase_period[4] = 0;
    for (int ph = 0; ph < PHASES; ph++) begin
      rand_period = 10'(phase_period[ph]);
      write_period(rand_period);
      // one phase runs with no idling on either side
      gaps_on  = (ph != 2);
      stall_on <= (ph != 2);
      phase_target = items_sent + RANDOM_ITEMS / PHASES;
      while (items_sent < phase_target) begin
        if ($urandom_range(19) == 0) run_message($urandom_range(MSG_DEPTH + 2, MSG_DEPTH - 2),
                                                 phase_period[ph]);
        else run_message($urandom_range(6, 1), phase_period[ph]);
      end
    end

    // drain and let the pipeline settle
    wait_idle();
    repeat (8) @(posedge clk);

    $display("run covered %0d items over %0d period writes, %0d result items checked",
             items_sent, period_writes, results_seen);
    $display("line bits %0d, messages finished %0d, mismatches %0d",
             bits_seen, messages_seen, mismatches);
    if (mismatches == 0 && results_due == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

@@ files.f @@
+incdir+rtl
rtl/bcdfs_pkg.sv
rtl/bcdfs_if.sv
rtl/bcdfs_ctrl.sv
rtl/bcdfs_skid.sv
rtl/bcd_digit_frame_serializer.sv
sim/bcdfs_line_monitor.sv
sim/bcd_digit_frame_serializer_tb.sv
